// File: rtl/mps_pkg.sv
package mps_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int MAX_STRIDE = 8;
	localparam int SAMPLE_BITS = 16;

	localparam int WIDTH_BITS = 7;
	localparam int STRIDE_BITS = 4;
	localparam int CHANS_BITS = 11;
	localparam int CHAN_BITS = 10;
	localparam int COORD_BITS = 6;
	localparam int WIN_BITS = 3;
	localparam int REM_BITS = 4;
	localparam int MAX_CHANS = 1024;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 11;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_STRIDE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd2;

	localparam logic [WIDTH_BITS-1:0] MAP_WIDTH_RST = 7'd8;
	localparam logic [STRIDE_BITS-1:0] POOL_STRIDE_RST = 4'd2;
	localparam logic [CHANS_BITS-1:0] CHANNEL_COUNT_RST = 11'd1;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;
	localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic first_col;
		logic col_end;
		logic first_row;
		logic row_end;
		logic [COORD_BITS-1:0] slot;
		logic [COORD_BITS-1:0] out_row;
		logic [CHAN_BITS-1:0] chan;
		logic last_ch;
		logic last_fr;
		logic bad;
	} cmd_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] pooled;
		logic [CHAN_BITS-1:0] chan;
		logic [COORD_BITS-1:0] out_row;
		logic [COORD_BITS-1:0] out_col;
		logic last_ch;
		logic last_fr;
		logic bad;
	} res_t;

endpackage

// File: rtl/mps_fifo.sv
module mps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_BITS-1:0] wptr_q;
	logic [PTR_BITS-1:0] rptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign dout = store_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/mps_front.sv
module mps_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  logic signed [mps_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                   full,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mps_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [mps_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                   cmd_full,
	output logic                                   cmd_push,
	output mps_pkg::cmd_t                          cmd
);

	localparam int WB = mps_pkg::WIDTH_BITS;
	localparam int SB = mps_pkg::STRIDE_BITS;
	localparam int NB = mps_pkg::CHANS_BITS;
	localparam int CB = mps_pkg::COORD_BITS;
	localparam int KB = mps_pkg::WIN_BITS;
	localparam int HB = mps_pkg::CHAN_BITS;
	localparam int RB = mps_pkg::REM_BITS;

	logic [WB-1:0] map_width_q;
	logic [SB-1:0] pool_stride_q;
	logic [NB-1:0] channel_count_q;

	logic [WB-1:0] width_n;
	logic [SB-1:0] stride_n;
	logic [NB-1:0] chans_n;
	logic cfg_hit;

	// remainder check of map width by stride, one bit a cycle
	logic busy_q;
	logic rem_bad_q;
	logic [WB-1:0] wsh_q;
	logic [RB-1:0] rem_q;
	logic [KB-1:0] step_q;
	logic [RB:0] rem_sh;
	logic [RB:0] rem_n;

	logic [CB-1:0] in_col_q;
	logic [CB-1:0] in_row_q;
	logic [KB-1:0] col_win_q;
	logic [KB-1:0] row_win_q;
	logic [CB-1:0] out_col_q;
	logic [CB-1:0] out_row_q;
	logic [HB-1:0] chan_q;

	logic range_bad;
	logic bad_now;
	logic accept;
	logic col_end;
	logic row_end;
	logic col_last;
	logic row_last;
	logic chan_last;
	logic [NB-1:0] chans_eff;

	function automatic logic [KB:0] stride_bits(input logic [SB-1:0] s);
		stride_bits = s[KB:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_comb begin
		width_n = map_width_q;
		stride_n = pool_stride_q;
		chans_n = channel_count_q;
		cfg_hit = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_index)
				mps_pkg::CFG_MAP_WIDTH: begin
					width_n = cfg_data[WB-1:0];
					cfg_hit = 1'b1;
				end
				mps_pkg::CFG_POOL_STRIDE: begin
					stride_n = cfg_data[SB-1:0];
					cfg_hit = 1'b1;
				end
				mps_pkg::CFG_CHANNEL_COUNT: begin
					chans_n = cfg_data[NB-1:0];
					cfg_hit = 1'b1;
				end
				default: begin
					cfg_hit = 1'b0;
				end
			endcase
		end
	end

	assign rem_sh = {rem_q, wsh_q[WB-1]};
	assign rem_n = (rem_sh >= {1'b0, pool_stride_q}) ? rem_sh - {1'b0, pool_stride_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= mps_pkg::MAP_WIDTH_RST;
			pool_stride_q <= mps_pkg::POOL_STRIDE_RST;
			channel_count_q <= mps_pkg::CHANNEL_COUNT_RST;
			busy_q <= 1'b0;
			rem_bad_q <= 1'b0;
			wsh_q <= '0;
			rem_q <= '0;
			step_q <= '0;
		end else if (cfg_hit) begin
			map_width_q <= width_n;
			pool_stride_q <= stride_n;
			channel_count_q <= chans_n;
			busy_q <= 1'b1;
			wsh_q <= width_n;
			rem_q <= '0;
			step_q <= KB'(WB - 1);
		end else if (busy_q) begin
			wsh_q <= {wsh_q[WB-2:0], 1'b0};
			rem_q <= rem_n[RB-1:0];
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
				rem_bad_q <= (rem_n[RB-1:0] != '0);
			end
		end
	end

	assign range_bad = (map_width_q == '0) || (map_width_q > WB'(mps_pkg::MAX_WIDTH))
		|| (pool_stride_q == '0) || (pool_stride_q > SB'(mps_pkg::MAX_STRIDE));
	assign bad_now = range_bad || rem_bad_q;

	assign full = cmd_full || busy_q;
	assign accept = push && !full;
	assign cmd_push = accept;

	always_comb begin
		if (channel_count_q == '0) begin
			chans_eff = NB'(1);
		end else if (channel_count_q > NB'(mps_pkg::MAX_CHANS)) begin
			chans_eff = NB'(mps_pkg::MAX_CHANS);
		end else begin
			chans_eff = channel_count_q;
		end
	end

	assign col_end = ({1'b0, col_win_q} + 1'b1) >= stride_bits(pool_stride_q);
	assign row_end = ({1'b0, row_win_q} + 1'b1) >= stride_bits(pool_stride_q);
	assign col_last = ({1'b0, in_col_q} + 1'b1) >= map_width_q;
	assign row_last = ({1'b0, in_row_q} + 1'b1) >= map_width_q;
	assign chan_last = ({1'b0, chan_q} + 1'b1) >= chans_eff;

	always_comb begin
		cmd.sample = sample;
		cmd.first_col = (col_win_q == '0);
		cmd.col_end = col_end;
		cmd.first_row = (row_win_q == '0);
		cmd.row_end = row_end;
		cmd.slot = out_col_q;
		cmd.out_row = out_row_q;
		cmd.chan = chan_q;
		cmd.last_ch = row_last && col_last;
		cmd.last_fr = row_last && col_last && chan_last;
		cmd.bad = bad_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			col_win_q <= '0;
			row_win_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			chan_q <= '0;
		end else if (cfg_hit) begin
			in_col_q <= '0;
			in_row_q <= '0;
			col_win_q <= '0;
			row_win_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			chan_q <= '0;
		end else if (accept && !bad_now) begin
			if (col_last) begin
				in_col_q <= '0;
				col_win_q <= '0;
				out_col_q <= '0;
				if (row_last) begin
					in_row_q <= '0;
					row_win_q <= '0;
					out_row_q <= '0;
					chan_q <= chan_last ? '0 : chan_q + 1'b1;
				end else begin
					in_row_q <= in_row_q + 1'b1;
					if (row_end) begin
						row_win_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						row_win_q <= row_win_q + 1'b1;
					end
				end
			end else begin
				in_col_q <= in_col_q + 1'b1;
				if (col_end) begin
					col_win_q <= '0;
					out_col_q <= out_col_q + 1'b1;
				end else begin
					col_win_q <= col_win_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/mps_back.sv
module mps_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mps_pkg::cmd_t                       cmd,
	input  logic                                cmd_empty,
	output logic                                cmd_pop,
	input  logic [mps_pkg::RES_CNT_BITS-1:0]    res_count,
	output logic                                res_push,
	output mps_pkg::res_t                       res
);

	localparam int DB = mps_pkg::SAMPLE_BITS;
	localparam int CB = mps_pkg::COORD_BITS;
	localparam int NB = mps_pkg::RES_CNT_BITS;

	logic signed [DB-1:0] colmax_mem_q [mps_pkg::MAX_WIDTH];
	logic signed [DB-1:0] run_q;
	logic signed [DB-1:0] run_n;

	logic valid_s1;
	mps_pkg::cmd_t cmd_s1;
	logic signed [DB-1:0] run_s1;
	logic signed [DB-1:0] rd_s1;

	logic [NB:0] used;
	logic wr_en;
	logic [CB-1:0] wr_slot;
	logic signed [DB-1:0] colmax;

	// reserve result room for the item already in flight
	assign used = {1'b0, res_count} + {{NB{1'b0}}, valid_s1};
	assign cmd_pop = !cmd_empty && (used < (NB + 1)'(mps_pkg::RES_DEPTH));

	assign run_n = (cmd.first_col || (cmd.sample > run_q)) ? cmd.sample : run_q;

	assign colmax = (cmd_s1.first_row || (run_s1 > rd_s1)) ? run_s1 : rd_s1;
	assign wr_en = valid_s1 && !cmd_s1.bad && cmd_s1.col_end;
	assign wr_slot = cmd_s1.slot;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			colmax_mem_q[wr_slot] <= colmax;
		end
		if (cmd_pop) begin
			cmd_s1 <= cmd;
			run_s1 <= run_n;
			rd_s1 <= (wr_en && (wr_slot == cmd.slot)) ? colmax : colmax_mem_q[cmd.slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			run_q <= '0;
		end else begin
			valid_s1 <= cmd_pop;
			if (cmd_pop && !cmd.bad) begin
				run_q <= run_n;
			end
		end
	end

	assign res_push = valid_s1 && (cmd_s1.bad || (cmd_s1.col_end && cmd_s1.row_end));

	always_comb begin
		if (cmd_s1.bad) begin
			res = '0;
			res.bad = 1'b1;
		end else begin
			res.pooled = colmax;
			res.chan = cmd_s1.chan;
			res.out_row = cmd_s1.out_row;
			res.out_col = cmd_s1.slot;
			res.last_ch = cmd_s1.last_ch;
			res.last_fr = cmd_s1.last_fr;
			res.bad = 1'b0;
		end
	end

endmodule

// File: rtl/max_pool_2d_stream.sv
// Streaming 2-D max pooling over square feature maps with non-overlapping windows.
// Samples (signed Q8.8) come in raster order, one map per channel and channels back to
// back; each result is the maximum of one pool_stride x pool_stride window, tagged with
// channel, output row and column and with end-of-channel and end-of-frame marks. The
// block takes one sample per clock while full is low and gives at most one result per
// clock; a result passes through the command queue, the back stage register and the
// result queue on its way to the result ports. Any register write sets the stream back
// to the start of a frame and then runs a check of map width against stride, one bit
// per cycle, during which full stays high; a write to an unused index does nothing. A
// map width that is zero, over 64, or not a multiple of the stride (or a stride of zero
// or over 8) yields one result per sample with bad_config set and all else zero.
// Registers: 0 map_width (reset 8), 1 pool_stride (reset 2), 2 channel_count (reset 1;
// zero acts as one, above 1024 as 1024).
module max_pool_2d_stream (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [mps_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [mps_pkg::SAMPLE_BITS-1:0] pooled,
	output logic [mps_pkg::CHAN_BITS-1:0]          chan_index,
	output logic [mps_pkg::COORD_BITS-1:0]         out_row,
	output logic [mps_pkg::COORD_BITS-1:0]         out_col,
	output logic                                   last_of_channel,
	output logic                                   last_of_frame,
	output logic                                   bad_config,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mps_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [mps_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int CMD_W = $bits(mps_pkg::cmd_t);
	localparam int RES_W = $bits(mps_pkg::res_t);

	mps_pkg::cmd_t front_cmd;
	mps_pkg::cmd_t queue_cmd;
	logic cmd_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;

	mps_pkg::res_t back_res;
	mps_pkg::res_t head_res;
	logic res_push;
	logic [mps_pkg::RES_CNT_BITS-1:0] res_count;

	// Front: configuration, position counters, window classification.
	mps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (front_cmd)
	);

	// Short queue of classified items between front and back.
	mps_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (mps_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (front_cmd),
		.pop    (cmd_pop),
		.dout   (queue_cmd),
		.full   (cmd_full),
		.empty  (cmd_empty),
		.count  ()
	);

	// Back: running row max, per-column partial max memory, result build.
	mps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queue_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (back_res)
	);

	// Result queue: hold finished items until the consumer pops them.
	mps_fifo #(
		.WIDTH (RES_W),
		.DEPTH (mps_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (back_res),
		.pop    (pop),
		.dout   (head_res),
		.full   (),
		.empty  (empty),
		.count  (res_count)
	);

	assign pooled = head_res.pooled;
	assign chan_index = head_res.chan;
	assign out_row = head_res.out_row;
	assign out_col = head_res.out_col;
	assign last_of_channel = head_res.last_ch;
	assign last_of_frame = head_res.last_fr;
	assign bad_config = head_res.bad;

endmodule
